### hw/rtl/id3p_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// id3p_pkg
// Types and constants shared by the ID3v2.3 tag stream parser.
// ----------------------------------------------------------------------------
package id3p_pkg;

    localparam int TDATA_W  = 112;
    localparam int HDR_LEN  = 10;
    localparam int EXT_LEN  = 4;
    localparam int FHB_N    = 9;

    localparam logic [7:0] MAGIC_0      = 8'h49;
    localparam logic [7:0] MAGIC_1      = 8'h44;
    localparam logic [7:0] MAGIC_2      = 8'h33;
    localparam logic [7:0] MAGIC_VER    = 8'h03;
    localparam logic [7:0] FLAG_UNSYNC  = 8'h80;
    localparam logic [7:0] FLAG_EXT     = 8'h40;
    localparam logic [7:0] BYTE_FF      = 8'hFF;
    localparam logic [7:0] BYTE_ZERO    = 8'h00;
    localparam logic [7:0] SYNCSAFE_MSK = 8'h7F;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_EXT_SIZE,
        PH_EXT_SKIP,
        PH_FRAME_HDR,
        PH_PAYLOAD,
        PH_PADDING,
        PH_IDLE
    } phase_t;

    typedef enum logic [2:0] {
        KIND_PAYLOAD   = 3'd0,
        KIND_FRAME_HDR = 3'd1,
        KIND_TAG_OK    = 3'd2,
        KIND_NOT_ID3   = 3'd3,
        KIND_MALFORMED = 3'd4
    } kind_t;

    typedef struct packed {
        phase_t      phase;
        logic [3:0]  pos;
        logic [7:0]  hflags;
        logic [27:0] raw_rem;
        logic        after_ff;
        logic [31:0] ext_rem;
        logic [31:0] frame_rem;
        logic [27:0] total;
        logic        frame_seen;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:      PH_HEADER,
        pos:        4'd0,
        hflags:     8'd0,
        raw_rem:    28'd0,
        after_ff:   1'b0,
        ext_rem:    32'd0,
        frame_rem:  32'd0,
        total:      28'd0,
        frame_seen: 1'b0
    };

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic [31:0] frame_id;
        logic [31:0] frame_size;
        logic [5:0]  frame_flags;
        logic        id_ok;
        logic [27:0] tag_size;
        logic        run_end;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } push_t;

    typedef logic [FHB_N-1:0][7:0] fhb_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        unique case (idx)
            2'd0:    m = MAGIC_0;
            2'd1:    m = MAGIC_1;
            2'd2:    m = MAGIC_2;
            default: m = MAGIC_VER;
        endcase
        return m;
    endfunction

    function automatic logic id_char_ok(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h30) && (c <= 8'h39));
    endfunction

endpackage
`default_nettype wire

### hw/rtl/id3p_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// id3p_step
// Single-pass next-state and result logic for one raw tag byte.
// ----------------------------------------------------------------------------
module id3p_step (
    input  wire id3p_pkg::state_t st,
    input  wire id3p_pkg::fhb_t   fhb,
    input  wire logic [7:0]       data_byte,
    input  wire logic             start_of_tag,
    output id3p_pkg::state_t      st_next,
    output logic                  fhb_we,
    output logic [3:0]            fhb_idx,
    output id3p_pkg::push_t       results
);
    import id3p_pkg::*;

    state_t      s;
    state_t      n;
    res_t        ra;
    res_t        rf;
    logic        ta;
    logic        fin;
    logic        drop;
    logic        boundary;
    logic [31:0] sz;

    always_comb
    begin
        s        = start_of_tag ? STATE_RESET : st;
        n        = s;
        ra       = '0;
        rf       = '0;
        ta       = 1'b0;
        fin      = 1'b0;
        drop     = 1'b0;
        boundary = 1'b0;
        fhb_we   = 1'b0;
        fhb_idx  = s.pos;
        sz       = {fhb[4], fhb[5], fhb[6], fhb[7]};
        results  = '0;

        if (s.phase == PH_IDLE)
        begin
            n = s;
        end
        else if (s.phase == PH_HEADER)
        begin
            if ((s.pos < 4'd4) && (data_byte != magic_byte(s.pos[1:0])))
            begin
                ra.kind = KIND_NOT_ID3;
                ta      = 1'b1;
                n.phase = PH_IDLE;
            end
            else
            begin
                if (s.pos == 4'd5)
                    n.hflags = data_byte;
                if (s.pos >= 4'd6)
                    n.raw_rem = {s.raw_rem[20:0], data_byte[6:0] & SYNCSAFE_MSK[6:0]};
                n.pos = s.pos + 4'd1;
                if (s.pos == 4'(HDR_LEN - 1))
                begin
                    n.pos      = 4'd0;
                    n.after_ff = 1'b0;
                    n.phase    = ((n.hflags & FLAG_EXT) != 8'd0) ? PH_EXT_SIZE : PH_FRAME_HDR;
                    fin        = (n.raw_rem == 28'd0);
                end
            end
        end
        else
        begin
            n.raw_rem = s.raw_rem - 28'd1;
            drop = ((s.hflags & FLAG_UNSYNC) != 8'd0) && s.after_ff
                   && (data_byte == BYTE_ZERO);
            n.after_ff = drop ? 1'b0 : (data_byte == BYTE_FF);
            if (!drop)
            begin
                unique case (s.phase)
                    PH_EXT_SIZE:
                    begin
                        n.ext_rem = {s.ext_rem[23:0], data_byte};
                        n.pos     = s.pos + 4'd1;
                        if (s.pos == 4'(EXT_LEN - 1))
                        begin
                            n.pos   = 4'd0;
                            n.phase = (n.ext_rem != 32'd0) ? PH_EXT_SKIP : PH_FRAME_HDR;
                        end
                    end
                    PH_EXT_SKIP:
                    begin
                        n.ext_rem = s.ext_rem - 32'd1;
                        if (n.ext_rem == 32'd0)
                            n.phase = PH_FRAME_HDR;
                    end
                    PH_FRAME_HDR:
                    begin
                        if ((s.pos == 4'd0) && (data_byte == BYTE_ZERO))
                        begin
                            n.phase = PH_PADDING;
                        end
                        else if (s.pos == 4'(HDR_LEN - 1))
                        begin
                            ra.kind        = KIND_FRAME_HDR;
                            ra.frame_id    = {fhb[0], fhb[1], fhb[2], fhb[3]};
                            ra.frame_size  = sz;
                            ra.frame_flags = {fhb[8][7:5], data_byte[7:5]};
                            ra.id_ok       = id_char_ok(fhb[0]) && id_char_ok(fhb[1])
                                             && id_char_ok(fhb[2]) && id_char_ok(fhb[3]);
                            ta             = 1'b1;
                            n.total        = s.total + sz[27:0] + 28'(HDR_LEN);
                            n.frame_seen   = 1'b1;
                            n.frame_rem    = sz;
                            n.pos          = 4'd0;
                            n.phase        = (sz != 32'd0) ? PH_PAYLOAD : PH_FRAME_HDR;
                        end
                        else
                        begin
                            fhb_we = 1'b1;
                            n.pos  = s.pos + 4'd1;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        ra.kind         = KIND_PAYLOAD;
                        ra.payload_byte = data_byte;
                        ta              = 1'b1;
                        n.frame_rem     = s.frame_rem - 32'd1;
                        if (n.frame_rem == 32'd0)
                            n.phase = PH_FRAME_HDR;
                    end
                    default:
                    begin
                        n.pos = s.pos;
                    end
                endcase
            end
            fin = (n.raw_rem == 28'd0);
        end

        if (fin)
        begin
            boundary = ((n.phase == PH_FRAME_HDR) && (n.pos == 4'd0))
                       || (n.phase == PH_PADDING);
            if (boundary && n.frame_seen)
            begin
                rf.kind     = KIND_TAG_OK;
                rf.tag_size = n.total;
            end
            else
            begin
                rf.kind = KIND_MALFORMED;
            end
            n.phase = PH_IDLE;
        end

        if (ta && fin)
        begin
            results.count      = 2'd2;
            results.r0         = ra;
            results.r1         = rf;
            results.r1.run_end = 1'b1;
        end
        else if (ta)
        begin
            results.count      = 2'd1;
            results.r0         = ra;
            results.r0.run_end = 1'b1;
        end
        else if (fin)
        begin
            results.count      = 2'd1;
            results.r0         = rf;
            results.r0.run_end = 1'b1;
        end

        st_next = n;
    end

endmodule
`default_nettype wire

### hw/rtl/id3p_rqueue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// id3p_rqueue
// Three-entry shifting result queue; takes up to two words a cycle.
// ----------------------------------------------------------------------------
module id3p_rqueue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire id3p_pkg::push_t push,
    input  wire logic            out_ready,
    output id3p_pkg::res_t       head,
    output logic                 head_valid,
    output logic                 room
);
    import id3p_pkg::*;

    res_t       slot_reg  [3];
    res_t       slot_next [3];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [1:0] count_after;
    logic       pop;

    assign head_valid  = (count_reg != 2'd0);
    assign head        = slot_reg[0];
    assign pop         = head_valid && out_ready;
    assign count_after = count_reg - {1'b0, pop};
    assign room        = (count_after <= 2'd1);
    assign count_next  = count_after + push.count;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            slot_next[i] = slot_reg[i];
            if (pop && (i < 2))
                slot_next[i] = slot_reg[i + 1];
            if ((push.count != 2'd0) && (count_after == 2'(i)))
                slot_next[i] = push.r0;
            if ((push.count == 2'd2) && ((count_after + 2'd1) == 2'(i)))
                slot_next[i] = push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            slot_reg[i] <= slot_next[i];
    end

endmodule
`default_nettype wire

### hw/rtl/id3v2_tag_stream_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// id3v2_tag_stream_parser
// ID3v2.3 tag parser: header check, de-unsynchronisation, frame walk.
// ----------------------------------------------------------------------------
// One raw tag byte is taken per cycle while s_tready is high. Its results
// are registered into a three-word output queue when the byte is
// accepted. The master side moves one word per cycle while m_tready is
// high; a byte that yields two words (a frame header or payload byte that
// also ends the tag) keeps the queue one word fuller, and the slave side
// pauses only when the queue cannot take two more words.
// ----------------------------------------------------------------------------
module id3v2_tag_stream_parser (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // data_byte
    input  wire logic         s_tuser,   // start_of_tag
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [111:0]      m_tdata,   // payload_byte, frame_id, frame_size,
                                         // frame_flags, id_ok, tag_size, zero fill
    output logic [2:0]        m_tuser,   // result_kind
    output logic              m_tlast    // run_end
);
    import id3p_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    fhb_t       fhb_reg;
    logic       fhb_we;
    logic [3:0] fhb_idx;
    push_t      step_res;
    push_t      push;
    res_t       head;
    logic       accept;

    assign accept = s_tvalid && s_tready;

    id3p_step u_step (
        .st           (state_reg),
        .fhb          (fhb_reg),
        .data_byte    (s_tdata),
        .start_of_tag (s_tuser),
        .st_next      (state_next),
        .fhb_we       (fhb_we),
        .fhb_idx      (fhb_idx),
        .results      (step_res)
    );

    always_comb
    begin
        push       = step_res;
        push.count = accept ? step_res.count : 2'd0;
    end

    id3p_rqueue u_rqueue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .out_ready  (m_tready),
        .head       (head),
        .head_valid (m_tvalid),
        .room       (s_tready)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (accept)
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && fhb_we)
            fhb_reg[fhb_idx] <= s_tdata;
    end

    assign m_tdata = {5'd0, head.tag_size, head.id_ok, head.frame_flags,
                      head.frame_size, head.frame_id, head.payload_byte};
    assign m_tuser = head.kind;
    assign m_tlast = head.run_end;

endmodule
`default_nettype wire

### tb/id3v2_tag_stream_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3v2_tag_stream_parser_tb
// Self-checking bench for the ID3v2.3 tag stream parser. Raw tag bytes are
// streamed in (valid headers, bad headers, unsynchronised bodies, extended
// headers, frames, padding, truncated and overlong tags) under varying
// source and sink stalls; every output word is checked against a
// behavioral decoder of the tag format.
// ----------------------------------------------------------------------------
module id3v2_tag_stream_parser_tb;

    import id3p_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       sot;
    } tag_byte_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [7:0]     s_tdata = 8'h00;
    logic           s_tuser = 1'b0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [111:0]   m_tdata;
    logic [2:0]     m_tuser;
    logic           m_tlast;

    tag_byte_t      pending_bytes [$];
    res_t           expected_words [$];
    int unsigned    tx_idle_pct = 0;
    int unsigned    rx_idle_pct = 0;
    int unsigned    sent_count = 0;
    int unsigned    mismatches = 0;

    logic [7:0]     tag_magic [4] = '{MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_VER};

    // decoder state
    phase_t         st_phase;
    logic [3:0]     st_pos;
    logic [7:0]     st_hflags;
    logic [27:0]    st_raw_left;
    logic           st_after_ff;
    logic [31:0]    st_ext_left;
    logic [7:0]     st_hdr_bytes [10];
    logic [31:0]    st_payload_left;
    logic [27:0]    st_frames_len;
    logic           st_saw_frame;

    id3v2_tag_stream_parser uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic void clear_decoder();
        st_phase        = PH_HEADER;
        st_pos          = 4'd0;
        st_hflags       = 8'h00;
        st_raw_left     = 28'd0;
        st_after_ff     = 1'b0;
        st_ext_left     = 32'd0;
        st_payload_left = 32'd0;
        st_frames_len   = 28'd0;
        st_saw_frame    = 1'b0;
    endfunction

    function automatic logic upper_or_digit(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic void emit_word(input kind_t k, input logic [7:0] pb,
                                      input logic [31:0] fid, input logic [31:0] fsz,
                                      input logic [5:0] ffl, input logic fok,
                                      input logic [27:0] tsz);
        res_t w;
        w.kind         = k;
        w.payload_byte = pb;
        w.frame_id     = fid;
        w.frame_size   = fsz;
        w.frame_flags  = ffl;
        w.id_ok        = fok;
        w.tag_size     = tsz;
        w.run_end      = 1'b0;
        expected_words.push_back(w);
    endfunction

    function automatic void close_tag();
        if ((((st_phase == PH_FRAME_HDR) && (st_pos == 4'd0)) || (st_phase == PH_PADDING))
            && st_saw_frame)
            emit_word(KIND_TAG_OK, 8'h00, 32'd0, 32'd0, 6'd0, 1'b0, st_frames_len);
        else
            emit_word(KIND_MALFORMED, 8'h00, 32'd0, 32'd0, 6'd0, 1'b0, 28'd0);
        st_phase = PH_IDLE;
    endfunction

    function automatic void header_byte(input logic [7:0] b);
        if ((st_pos < 4'd4) && (b != tag_magic[st_pos[1:0]]))
        begin
            emit_word(KIND_NOT_ID3, 8'h00, 32'd0, 32'd0, 6'd0, 1'b0, 28'd0);
            st_phase = PH_IDLE;
            return;
        end
        if (st_pos == 4'd5)
            st_hflags = b;
        if (st_pos >= 4'd6)
            st_raw_left = {st_raw_left[20:0], b[6:0]};
        st_pos++;
        if (st_pos >= 4'd10)
        begin
            st_pos      = 4'd0;
            st_after_ff = 1'b0;
            st_phase    = st_hflags[6] ? PH_EXT_SIZE : PH_FRAME_HDR;
            if (st_raw_left == 28'd0)
                close_tag();
        end
    endfunction

    function automatic void body_byte(input logic [7:0] b);
        logic [31:0] fid;
        logic [31:0] fsz;
        logic [5:0]  ffl;
        logic        fok;
        case (st_phase)
            PH_EXT_SIZE:
            begin
                st_ext_left = {st_ext_left[23:0], b};
                st_pos++;
                if (st_pos >= 4'd4)
                begin
                    st_pos   = 4'd0;
                    st_phase = (st_ext_left != 32'd0) ? PH_EXT_SKIP : PH_FRAME_HDR;
                end
            end
            PH_EXT_SKIP:
            begin
                st_ext_left--;
                if (st_ext_left == 32'd0)
                    st_phase = PH_FRAME_HDR;
            end
            PH_FRAME_HDR:
            begin
                if ((st_pos == 4'd0) && (b == 8'h00))
                    st_phase = PH_PADDING;
                else
                begin
                    st_hdr_bytes[st_pos] = b;
                    st_pos++;
                    if (st_pos >= 4'd10)
                    begin
                        fid = {st_hdr_bytes[0], st_hdr_bytes[1], st_hdr_bytes[2],
                               st_hdr_bytes[3]};
                        fsz = {st_hdr_bytes[4], st_hdr_bytes[5], st_hdr_bytes[6],
                               st_hdr_bytes[7]};
                        ffl = {st_hdr_bytes[8][7:5], st_hdr_bytes[9][7:5]};
                        fok = upper_or_digit(st_hdr_bytes[0]) && upper_or_digit(st_hdr_bytes[1])
                              && upper_or_digit(st_hdr_bytes[2])
                              && upper_or_digit(st_hdr_bytes[3]);
                        emit_word(KIND_FRAME_HDR, 8'h00, fid, fsz, ffl, fok, 28'd0);
                        st_frames_len   = st_frames_len + 28'd10 + fsz[27:0];
                        st_saw_frame    = 1'b1;
                        st_payload_left = fsz;
                        st_pos          = 4'd0;
                        st_phase        = (fsz != 32'd0) ? PH_PAYLOAD : PH_FRAME_HDR;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                emit_word(KIND_PAYLOAD, b, 32'd0, 32'd0, 6'd0, 1'b0, 28'd0);
                st_payload_left--;
                if (st_payload_left == 32'd0)
                    st_phase = PH_FRAME_HDR;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void decode_tag_byte(input logic [7:0] b, input logic sot);
        int unsigned n0;
        res_t        last_word;
        n0 = expected_words.size();
        if (sot)
            clear_decoder();
        if (st_phase == PH_HEADER)
            header_byte(b);
        else if (st_phase != PH_IDLE)
        begin
            st_raw_left--;
            if (st_hflags[7] && st_after_ff && (b == 8'h00))
                st_after_ff = 1'b0;
            else
            begin
                st_after_ff = (b == 8'hFF);
                body_byte(b);
            end
            if (st_raw_left == 28'd0)
                close_tag();
        end
        if (expected_words.size() > n0)
        begin
            last_word = expected_words.pop_back();
            last_word.run_end = 1'b1;
            expected_words.push_back(last_word);
        end
    endfunction

    // source side
    always @(posedge clk)
    begin : feed
        tag_byte_t nxt;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if ((pending_bytes.size() != 0) && ($urandom_range(0, 99) >= tx_idle_pct))
            begin
                nxt = pending_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.data;
                s_tuser  <= nxt.sot;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // sink side
    always @(posedge clk)
    begin
        m_tready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // predict on accepted input words, check accepted output words
    always @(posedge clk)
    begin : watch
        res_t want;
        logic bad;
        if (!rst_n)
            clear_decoder();
        else
        begin
            if (s_tvalid && s_tready)
                decode_tag_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: kind %0d tdata %h last %b",
                                 m_tuser, m_tdata, m_tlast);
                end
                else
                begin
                    want = expected_words.pop_front();
                    bad = (m_tuser !== want.kind) || (m_tdata[7:0] !== want.payload_byte)
                          || (m_tdata[39:8] !== want.frame_id)
                          || (m_tdata[71:40] !== want.frame_size)
                          || (m_tdata[77:72] !== want.frame_flags)
                          || (m_tdata[78] !== want.id_ok)
                          || (m_tdata[106:79] !== want.tag_size)
                          || (m_tdata[111:107] !== 5'd0)
                          || (m_tlast !== want.run_end);
                    if (bad)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $write("mismatch (exp/act): kind %0d/%0d byte %h/%h id %h/%h",
                                   want.kind, m_tuser, want.payload_byte, m_tdata[7:0],
                                   want.frame_id, m_tdata[39:8]);
                            $display(" size %h/%h flags %h/%h ok %b/%b tag %h/%h last %b/%b fill %h",
                                     want.frame_size, m_tdata[71:40],
                                     want.frame_flags, m_tdata[77:72],
                                     want.id_ok, m_tdata[78],
                                     want.tag_size, m_tdata[106:79],
                                     want.run_end, m_tlast, m_tdata[111:107]);
                        end
                    end
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic sot);
        tag_byte_t item;
        item.data = b;
        item.sot  = sot;
        pending_bytes.push_back(item);
        sent_count++;
    endtask

    task automatic send_header(input logic [7:0] flags, input logic [27:0] size,
                               input logic [7:0] rev);
        int k;
        send_byte(MAGIC_0, 1'b1);
        send_byte(MAGIC_1, 1'b0);
        send_byte(MAGIC_2, 1'b0);
        send_byte(MAGIC_VER, 1'b0);
        send_byte(rev, 1'b0);
        send_byte(flags, 1'b0);
        // syncsafe size, bit 7 of each byte is don't-care
        for (k = 3; k >= 0; k--)
            send_byte({1'($urandom_range(0, 1)), size[7*k +: 7]}, 1'b0);
    endtask

    function automatic logic [7:0] biased_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 8'hFF;
        else if (r == 2)
            return 8'h00;
        return 8'($urandom);
    endfunction

    task automatic add_random_tag();
        logic [7:0]  body [$];
        logic [7:0]  raw [$];
        logic [7:0]  flags;
        logic [7:0]  b;
        logic [31:0] word32;
        int unsigned roll, i, k, n, len, cnt;
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            // broken magic/version at a random position
            n = $urandom_range(0, 3);
            for (i = 0; i <= n; i++)
            begin
                b = tag_magic[i];
                if (i == n)
                    b = b ^ (8'h01 << $urandom_range(0, 7));
                send_byte(b, i == 0);
            end
            cnt = $urandom_range(0, 3);
            for (i = 0; i < cnt; i++)
                send_byte(8'($urandom), 1'b0);
            return;
        end
        flags = 8'($urandom);
        if (roll < 12)
        begin
            // near-maximum size, cut short by the next tag
            send_header(flags, 28'hFFFFFFF - 28'($urandom_range(0, 3)), 8'($urandom));
            cnt = $urandom_range(1, 6);
            for (i = 0; i < cnt; i++)
                send_byte(biased_byte(), 1'b0);
            return;
        end
        if (flags[6])
        begin
            len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            word32 = len;
            for (k = 0; k < 4; k++)
                body.push_back(word32[31-8*k -: 8]);
            for (k = 0; k < len; k++)
                body.push_back(biased_byte());
        end
        n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
        for (i = 0; i < n; i++)
        begin
            for (k = 0; k < 4; k++)
            begin
                cnt = $urandom_range(0, 35);
                if ($urandom_range(0, 11) == 0)
                    body.push_back(8'($urandom));
                else
                    body.push_back((cnt < 26) ? 8'(8'h41 + cnt) : 8'(8'h30 + cnt - 26));
            end
            if ($urandom_range(0, 19) == 0)
            begin
                word32 = $urandom;
                len = $urandom_range(0, 4);
            end
            else
            begin
                len = $urandom_range(0, 6);
                word32 = len;
            end
            for (k = 0; k < 4; k++)
                body.push_back(word32[31-8*k -: 8]);
            body.push_back(8'($urandom));
            body.push_back(8'($urandom));
            for (k = 0; k < len; k++)
                body.push_back(biased_byte());
        end
        cnt = $urandom_range(0, 3);
        for (k = 0; k < cnt; k++)
            body.push_back((k == 0) ? 8'h00 : biased_byte());
        // unsynchronisation: stuff a zero after 0xFF, occasionally forgotten
        foreach (body[j])
        begin
            raw.push_back(body[j]);
            if (flags[7] && (body[j] == 8'hFF) && ($urandom_range(0, 15) != 0))
                raw.push_back(8'h00);
        end
        len = raw.size();
        roll = $urandom_range(0, 99);
        if (roll < 15)
            len = (len > 4) ? len - $urandom_range(1, 4) : 0;
        else if (roll < 30)
        begin
            cnt = $urandom_range(1, 4);
            for (k = 0; k < cnt; k++)
                raw.push_back(biased_byte());
            len = raw.size();
        end
        send_header(flags, 28'(len), 8'($urandom));
        cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len) : len;
        for (i = 0; i < cnt; i++)
            send_byte(raw[i], 1'b0);
        if ((cnt == len) && ($urandom_range(0, 3) == 0))
        begin
            n = $urandom_range(1, 2);
            for (i = 0; i < n; i++)
                send_byte(8'($urandom), 1'b0);
        end
    endtask

    task automatic wait_all_done();
        while ((pending_bytes.size() != 0) || s_tvalid || (expected_words.size() != 0))
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random(input int unsigned tx_pct, input int unsigned rx_pct,
                              input int unsigned n_bytes);
        int unsigned mark;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        mark = sent_count;
        while (sent_count - mark < n_bytes)
            add_random_tag();
        wait_all_done();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle_pct = 22;
        rx_idle_pct = 65;

        // bad magic on the first byte
        send_byte(8'h4A, 1'b1);
        // zero-size tag
        send_header(8'h40, 28'd0, 8'h00);
        // unsync tag: one frame, payload 0xFF, stuffed zero ends the tag
        send_header(8'h80, 28'd12, 8'hFF);
        send_byte(8'h54, 1'b0);
        send_byte(8'h49, 1'b0);
        send_byte(8'h54, 1'b0);
        send_byte(8'h32, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);

        run_random(22, 65, 140);
        run_random(65, 22, 140);
        run_random(0, 0, 140);
        repeat (12) @(posedge clk);

        if ((mismatches == 0) && (expected_words.size() == 0))
            $display("id3v2_tag_stream_parser regression: pass");
        else
            $display("id3v2_tag_stream_parser regression: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("id3v2_tag_stream_parser regression: fail");
        $finish;
    end

endmodule
